// File: rtl/assert_macros.svh
// Assertion macros shared by the version ring RTL.
// Expects i_clk and i_rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define MVR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define MVR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mvr_pkg.sv
// Package for the version ring: beat types, kind codes, ring helpers.
// No dependencies.
package mvr_pkg;

    localparam int HIST_DEPTH = 16;
    localparam int SLOT_W     = $clog2(HIST_DEPTH);
    localparam int APB_AW     = 3;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [3:0]        t_field_slot;
    typedef logic [63:0]       t_stamp;

    localparam t_slot          LAST_SLOT = t_slot'(HIST_DEPTH - 1);
    localparam logic [SLOT_W:0] DEPTH_X  = (SLOT_W + 1)'(HIST_DEPTH);
    localparam t_stamp         STAMP_INF = '1;

    localparam logic [2:0] KIND_READ     = 3'd0;
    localparam logic [2:0] KIND_SCAN     = 3'd1;
    localparam logic [2:0] KIND_PREWRITE = 3'd2;
    localparam logic [2:0] KIND_VALIDATE = 3'd3;
    localparam logic [2:0] KIND_FINALIZE = 3'd4;

    localparam logic REG_RR = 1'b0;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_ABORT = 1'b1;

    typedef struct packed {
        logic [2:0]  kind;
        t_stamp      txn_ts;
        t_stamp      txn_id;
        t_stamp      min_active_ts;
        t_stamp      commit_stamp;
        t_field_slot read_slot;
        logic        commit;
    } t_in_item;

    typedef struct packed {
        logic        status;
        t_field_slot slot;
        t_field_slot copy_from;
    } t_out_item;

    typedef struct packed {
        logic start;
        logic out_free;
        logic rr;
    } t_ctrl_req;

    typedef struct packed {
        logic ready;
        logic done;
    } t_ctrl_rsp;

    function automatic t_slot slot_next(input t_slot i);
        return (i == LAST_SLOT) ? '0 : i + t_slot'(1);
    endfunction

    function automatic t_slot slot_prev(input t_slot i);
        return (i == '0) ? LAST_SLOT : i - t_slot'(1);
    endfunction

    // slot lies between oldest and newest, ring order
    function automatic logic slot_live(input t_field_slot s, input t_slot o, input t_slot n);
        logic [SLOT_W:0] ds;
        logic [SLOT_W:0] dn;
        t_slot           si;
        si = t_slot'(s);
        ds = (si >= o) ? {1'b0, si} - {1'b0, o} : {1'b0, si} + DEPTH_X - {1'b0, o};
        dn = (n >= o)  ? {1'b0, n} - {1'b0, o}  : {1'b0, n} + DEPTH_X - {1'b0, o};
        if (32'(s) >= HIST_DEPTH) begin
            return 1'b0;
        end
        return ds <= dn;
    endfunction

endpackage

// File: rtl/mvr_cmp.sv
// Shared 64-bit magnitude comparator of the version ring sequencer.
// Depends on mvr_pkg.
module mvr_cmp (
    input  mvr_pkg::t_stamp i_a,
    input  mvr_pkg::t_stamp i_b,
    output logic            o_lt
);

    assign o_lt = (i_a < i_b);

endmodule

// File: rtl/mvr_ctrl.sv
// Version ring sequencer: stamp memories, ring pointers, one compare per cycle.
// Depends on mvr_pkg, mvr_cmp and assert_macros.svh.
`include "assert_macros.svh"

module mvr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mvr_pkg::t_ctrl_req  i_req,
    input  mvr_pkg::t_in_item   i_item,
    output mvr_pkg::t_ctrl_rsp  o_rsp,
    output mvr_pkg::t_out_item  o_res
);

    typedef enum logic [13:0] {
        S_INIT    = 14'b00000000000001,
        S_IDLE    = 14'b00000000000010,
        S_RD_OLD  = 14'b00000000000100,
        S_RD_NEW  = 14'b00000000001000,
        S_RD_WALK = 14'b00000000010000,
        S_PW_CHK  = 14'b00000000100000,
        S_PW_RECL = 14'b00000001000000,
        S_PW_WR   = 14'b00000010000000,
        S_VA_BEG  = 14'b00000100000000,
        S_VA_END  = 14'b00001000000000,
        S_FI_C1   = 14'b00010000000000,
        S_FI_C2   = 14'b00100000000000,
        S_FI_AB   = 14'b01000000000000,
        S_DONE    = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;
    mvr_pkg::t_slot r_newest, n_newest;
    mvr_pkg::t_slot r_oldest, n_oldest;
    mvr_pkg::t_slot r_idx, n_idx;
    logic r_wpend, n_wpend;
    mvr_pkg::t_in_item  r_item;
    mvr_pkg::t_out_item r_res, n_res;

    mvr_pkg::t_stamp mem_begin [mvr_pkg::HIST_DEPTH];
    mvr_pkg::t_stamp mem_end   [mvr_pkg::HIST_DEPTH];
    logic            mem_pend  [mvr_pkg::HIST_DEPTH];

    mvr_pkg::t_stamp r_rd_begin, r_rd_end;
    logic            r_rd_pend;
    mvr_pkg::t_slot  raddr;

    logic            we_b, we_e, we_p;
    mvr_pkg::t_slot  wa_b, wa_e, wa_p;
    mvr_pkg::t_stamp wd_b, wd_e;
    logic            wd_p;

    mvr_pkg::t_stamp cmp_a, cmp_b;
    logic            cmp_lt;
    mvr_pkg::t_slot  nxt_newest;
    logic            full;

    assign nxt_newest = mvr_pkg::slot_next(r_newest);
    assign full       = (nxt_newest == r_oldest);

    mvr_cmp u_cmp (
        .i_a  (cmp_a),
        .i_b  (cmp_b),
        .o_lt (cmp_lt)
    );

    always_ff @(posedge i_clk) begin
        if (we_b) begin
            mem_begin[wa_b] <= wd_b;
        end
        r_rd_begin <= mem_begin[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (we_e) begin
            mem_end[wa_e] <= wd_e;
        end
        r_rd_end <= mem_end[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (we_p) begin
            mem_pend[wa_p] <= wd_p;
        end
        r_rd_pend <= mem_pend[raddr];
    end

    always_comb begin
        n_state  = r_state;
        n_newest = r_newest;
        n_oldest = r_oldest;
        n_idx    = r_idx;
        n_wpend  = r_wpend;
        n_res    = r_res;
        raddr    = r_idx;
        cmp_a    = r_item.txn_ts;
        cmp_b    = r_rd_begin;
        we_b     = 1'b0;
        we_e     = 1'b0;
        we_p     = 1'b0;
        wa_b     = r_newest;
        wa_e     = r_newest;
        wa_p     = r_newest;
        wd_b     = r_item.commit_stamp;
        wd_e     = r_item.commit_stamp;
        wd_p     = 1'b0;
        unique case (r_state)
            S_INIT: begin
                we_b    = 1'b1;
                we_e    = 1'b1;
                we_p    = 1'b1;
                wa_b    = '0;
                wa_e    = '0;
                wa_p    = '0;
                wd_b    = '0;
                wd_e    = mvr_pkg::STAMP_INF;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                raddr = r_oldest;
                if (i_req.start) begin
                    n_res   = '{status: mvr_pkg::STATUS_ABORT, slot: '0, copy_from: '0};
                    n_state = S_DONE;
                    case (i_item.kind)
                        mvr_pkg::KIND_READ: begin
                            if (i_req.rr) begin
                                n_res.status = mvr_pkg::STATUS_OK;
                                n_res.slot   = mvr_pkg::t_field_slot'(r_newest);
                            end else begin
                                n_state = S_RD_OLD;
                            end
                        end
                        mvr_pkg::KIND_SCAN: begin
                            n_res.status = mvr_pkg::STATUS_OK;
                            n_res.slot   = mvr_pkg::t_field_slot'(r_newest);
                        end
                        mvr_pkg::KIND_PREWRITE: begin
                            raddr = r_newest;
                            if (!r_wpend) begin
                                n_state = S_PW_CHK;
                            end
                        end
                        mvr_pkg::KIND_VALIDATE: begin
                            raddr = mvr_pkg::t_slot'(i_item.read_slot);
                            n_idx = mvr_pkg::t_slot'(i_item.read_slot);
                            if (mvr_pkg::slot_live(i_item.read_slot, r_oldest, r_newest)) begin
                                n_state = S_VA_BEG;
                            end
                        end
                        mvr_pkg::KIND_FINALIZE: begin
                            if (r_wpend) begin
                                n_state = i_item.commit ? S_FI_C1 : S_FI_AB;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_RD_OLD: begin
                raddr = r_newest;
                if (cmp_lt) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_RD_NEW;
                end
            end
            S_RD_NEW: begin
                cmp_a = r_rd_begin;
                cmp_b = r_item.txn_ts;
                raddr = mvr_pkg::slot_prev(r_newest);
                n_idx = mvr_pkg::slot_prev(r_newest);
                if (cmp_lt) begin
                    n_res.status = mvr_pkg::STATUS_OK;
                    n_res.slot   = mvr_pkg::t_field_slot'(r_newest);
                    n_state      = S_DONE;
                end else if (r_newest == r_oldest) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_RD_WALK;
                end
            end
            S_RD_WALK: begin
                cmp_a = r_rd_begin;
                cmp_b = r_item.txn_ts;
                raddr = mvr_pkg::slot_prev(r_idx);
                if (cmp_lt) begin
                    n_res.status = mvr_pkg::STATUS_OK;
                    n_res.slot   = mvr_pkg::t_field_slot'(r_idx);
                    n_state      = S_DONE;
                end else if (r_idx == r_oldest) begin
                    n_state = S_DONE;
                end else begin
                    n_idx = mvr_pkg::slot_prev(r_idx);
                end
            end
            S_PW_CHK: begin
                raddr = r_oldest;
                if (cmp_lt) begin
                    n_state = S_DONE;
                end else if (full) begin
                    n_state = S_PW_RECL;
                end else begin
                    n_state = S_PW_WR;
                end
            end
            S_PW_RECL: begin
                cmp_a = r_rd_end;
                cmp_b = r_item.min_active_ts;
                raddr = mvr_pkg::slot_next(r_oldest);
                if (r_oldest != r_newest && cmp_lt) begin
                    n_oldest = mvr_pkg::slot_next(r_oldest);
                end else begin
                    n_state = S_PW_WR;
                end
            end
            S_PW_WR: begin
                we_b    = 1'b1;
                we_e    = 1'b1;
                we_p    = 1'b1;
                wa_b    = nxt_newest;
                wd_b    = r_item.txn_id;
                wd_e    = r_item.txn_id;
                wd_p    = 1'b1;
                n_wpend = 1'b1;
                if (full) begin
                    n_oldest = mvr_pkg::slot_next(r_oldest);
                end
                n_res.status    = mvr_pkg::STATUS_OK;
                n_res.slot      = mvr_pkg::t_field_slot'(nxt_newest);
                n_res.copy_from = mvr_pkg::t_field_slot'(r_newest);
                n_state         = S_DONE;
            end
            S_VA_BEG: begin
                if (cmp_lt) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_VA_END;
                end
            end
            S_VA_END: begin
                cmp_a = r_rd_end;
                cmp_b = r_item.commit_stamp;
                if (r_rd_pend || !cmp_lt) begin
                    n_res.status = mvr_pkg::STATUS_OK;
                end
                n_state = S_DONE;
            end
            S_FI_C1: begin
                we_b    = 1'b1;
                we_e    = 1'b1;
                we_p    = 1'b1;
                wa_b    = nxt_newest;
                n_state = S_FI_C2;
            end
            S_FI_C2: begin
                we_e     = 1'b1;
                we_p     = 1'b1;
                wa_e     = nxt_newest;
                wa_p     = nxt_newest;
                wd_e     = mvr_pkg::STAMP_INF;
                n_newest = nxt_newest;
                n_wpend  = 1'b0;
                n_res.status = mvr_pkg::STATUS_OK;
                n_res.slot   = mvr_pkg::t_field_slot'(nxt_newest);
                n_state      = S_DONE;
            end
            S_FI_AB: begin
                we_e    = 1'b1;
                we_p    = 1'b1;
                wd_e    = mvr_pkg::STAMP_INF;
                n_wpend = 1'b0;
                n_res.status = mvr_pkg::STATUS_OK;
                n_res.slot   = mvr_pkg::t_field_slot'(r_newest);
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_req.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_newest <= '0;
            r_oldest <= '0;
            r_wpend  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_newest <= n_newest;
            r_oldest <= n_oldest;
            r_wpend  <= n_wpend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_res <= n_res;
        if (i_req.start) begin
            r_item <= i_item;
        end
    end

    assign o_rsp.ready = (r_state == S_IDLE);
    assign o_rsp.done  = (r_state == S_DONE) && i_req.out_free;
    assign o_res       = r_res;

    `MVR_ASSERT_SAME(a_start_idle, i_req.start, r_state == S_IDLE, "beat taken while busy")
    `MVR_ASSERT_NEXT(a_done_idle, o_rsp.done, r_state == S_IDLE, "no return to idle")
    `MVR_ASSERT_NEXT(a_pw_pending, r_state == S_PW_WR, r_wpend, "prewrite left no pending")
    `MVR_ASSERT_NEXT(a_commit_adv, r_state == S_FI_C2,
                     r_newest == $past(nxt_newest) && !r_wpend, "commit did not advance")

endmodule

// File: rtl/mvcc_version_ring_top.sv
// Top level of the version ring: handshakes, result register, config port.
// Depends on mvr_pkg, mvr_ctrl.
//
// Keeps one row's ring of mvr_pkg::HIST_DEPTH versions and answers one beat at a time.
// An input beat is taken only while the sequencer is idle; its result lands in an output
// register, so the next beat may enter while a result still waits. All stamps live in
// small memories read one entry per cycle and checked by one shared 64-bit
// comparator, so the ring walk sets how long a beat takes: a read walks back from the
// newest version, a prewrite may reclaim from the oldest, and scan, finalize and
// rejected beats walk no ring. After reset the block seeds slot 0 in its init state
// before it takes its first beat. Register 0 (byte address 0, bit 0) is read_latest:
// when set, a read returns the newest version without checking stamps.
module mvcc_version_ring_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  mvr_pkg::t_in_item             i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output mvr_pkg::t_out_item            o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mvr_pkg::APB_AW-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic               r_rr;
    logic               r_out_valid;
    mvr_pkg::t_out_item r_out;
    mvr_pkg::t_ctrl_req req;
    mvr_pkg::t_ctrl_rsp rsp;
    mvr_pkg::t_out_item res;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == mvr_pkg::REG_RR);
    assign prdata = (paddr[2] == mvr_pkg::REG_RR) ? {31'b0, r_rr} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rr <= 1'b0;
        end else if (cfg_wr) begin
            r_rr <= pwdata[0];
        end
    end

    assign req.start    = i_in_valid && rsp.ready;
    assign req.out_free = !r_out_valid || i_out_ready;
    assign req.rr       = r_rr;

    mvr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .i_item  (i_in),
        .o_rsp   (rsp),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rsp.done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rsp.done) begin
            r_out <= res;
        end
    end

    assign o_in_ready  = rsp.ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
